/* hdl/spq_pkg.sv */
package spq_pkg;

    // default number of entries
    localparam int CAPACITY_DEF = 64;

    // field widths
    localparam int ID_W    = 16;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 7;

    // operation codes
    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_POP     = 2'd1,
        OP_UPGRADE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTLOWER = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    // request item
    typedef struct packed {
        t_op                       op;
        logic [ID_W-1:0]           patient_id;
        logic signed [PRIO_W-1:0]  priority_req;
    } t_in_item;

    // result item
    typedef struct packed {
        t_status                   status;
        logic [ID_W-1:0]           popped_id;
        logic [ID_W-1:0]           front_id;
        logic signed [PRIO_W-1:0]  front_priority;
        logic                      is_empty;
        logic [COUNT_W-1:0]        entry_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_step;
        logic apply;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_stat;

endpackage

/* hdl/spq_ctrl.sv */
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  spq_pkg::t_op      i_op,
    input  spq_pkg::t_dp_stat i_stat,
    output spq_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_stall
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == spq_pkg::OP_UPGRADE) begin
                        n_state = spq_pkg::S_SCAN;
                    end else begin
                        n_state = spq_pkg::S_APPLY;
                    end
                end
            end
            spq_pkg::S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = spq_pkg::S_APPLY;
                end
            end
            spq_pkg::S_APPLY: begin
                if (i_stat.out_free) begin
                    n_state = spq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.accept    = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.apply     = 1'b0;
        o_in_stall      = 1'b1;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                o_cmd.accept = i_in_valid;
                o_in_stall   = 1'b0;
            end
            spq_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            spq_pkg::S_APPLY: begin
                o_cmd.apply = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* hdl/spq_dp.sv */
module spq_dp #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_dp_cmd   i_cmd,
    input  spq_pkg::t_in_item  i_in_data,
    output spq_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spq_pkg::t_out_item o_out_data
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int NLEV  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LVL_W = (NLEV > 1) ? $clog2(NLEV) : 1;
    localparam int ID_W  = spq_pkg::ID_W;
    localparam int PR_W  = spq_pkg::PRIO_W;

    // sorted cell row
    logic [ID_W-1:0]        r_cell_id [CAPACITY];
    logic signed [PR_W-1:0] r_cell_pr [CAPACITY];
    logic [ID_W-1:0]        n_cell_id [CAPACITY];
    logic signed [PR_W-1:0] n_cell_pr [CAPACITY];
    logic [OCC_W-1:0]       r_occ;
    logic [OCC_W-1:0]       n_occ;

    // latched request
    spq_pkg::t_op           r_op;
    logic [ID_W-1:0]        r_id;
    logic signed [PR_W-1:0] r_pr;

    // per-cell compare masks and prefix scans
    logic [CAPACITY-1:0]    r_gt;
    logic [CAPACITY-1:0]    r_scan;
    logic [CAPACITY-1:0]    r_le;
    logic [LVL_W-1:0]       r_lvl;

    logic [CAPACITY-1:0]    cmp_gt;
    logic [CAPACITY-1:0]    cmp_match;
    logic [CAPACITY-1:0]    pre_excl;

    // result register
    logic                   r_out_valid;
    logic                   n_out_valid;
    spq_pkg::t_out_item     r_out;
    spq_pkg::t_out_item     n_out;

    logic                   full;
    logic                   empty;
    logic                   upg_ok;
    spq_pkg::t_status       status;

    // parallel compare of every cell against the incoming request
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            cmp_gt[k]    = (r_occ > OCC_W'(k)) && (r_cell_pr[k] > i_in_data.priority_req);
            cmp_match[k] = (r_occ > OCC_W'(k)) && (r_cell_id[k] == i_in_data.patient_id);
        end
    end

    // request and mask capture, prefix scan steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_in_data.op;
            r_id   <= i_in_data.patient_id;
            r_pr   <= i_in_data.priority_req;
            r_gt   <= cmp_gt;
            r_scan <= cmp_match;
            r_le   <= cmp_match & ~cmp_gt;
            r_lvl  <= '0;
        end else if (i_cmd.scan_step) begin
            r_scan <= r_scan | (r_scan << (32'd1 << r_lvl));
            r_le   <= r_le | (r_le << (32'd1 << r_lvl));
            r_lvl  <= r_lvl + LVL_W'(1);
        end
    end

    // match strictly ahead of each cell
    assign pre_excl = {r_scan[CAPACITY-2:0], 1'b0};

    assign full   = (r_occ == OCC_W'(CAPACITY));
    assign empty  = (r_occ == '0);
    assign upg_ok = r_scan[CAPACITY-1] && !r_le[CAPACITY-1];

    // operation outcome and new count
    always_comb begin
        status = spq_pkg::ST_OK;
        n_occ  = r_occ;
        unique case (r_op)
            spq_pkg::OP_INSERT: begin
                if (full) begin
                    status = spq_pkg::ST_FULL;
                end else begin
                    n_occ = r_occ + OCC_W'(1);
                end
            end
            spq_pkg::OP_POP: begin
                if (empty) begin
                    status = spq_pkg::ST_EMPTY;
                end else begin
                    n_occ = r_occ - OCC_W'(1);
                end
            end
            spq_pkg::OP_UPGRADE: begin
                priority if (empty) begin
                    status = spq_pkg::ST_EMPTY;
                end else if (!upg_ok) begin
                    status = spq_pkg::ST_NOTLOWER;
                end
            end
            spq_pkg::OP_CLEAR: begin
                n_occ = '0;
            end
            default: begin
                n_occ = r_occ;
            end
        endcase
    end

    // per-cell next value: hold, take left neighbor, take right neighbor or load new
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic                   prev_gt;
        logic [ID_W-1:0]        prev_id;
        logic signed [PR_W-1:0] prev_pr;
        logic [ID_W-1:0]        next_id;
        logic signed [PR_W-1:0] next_pr;
        logic                   ins_reg;
        logic                   upg_reg;

        if (k == 0) begin : g_first
            assign prev_gt = 1'b0;
            assign prev_id = r_cell_id[k];
            assign prev_pr = r_cell_pr[k];
        end else begin : g_rest
            assign prev_gt = r_gt[k-1];
            assign prev_id = r_cell_id[k-1];
            assign prev_pr = r_cell_pr[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign next_id = r_cell_id[k];
            assign next_pr = r_cell_pr[k];
        end else begin : g_inner
            assign next_id = r_cell_id[k+1];
            assign next_pr = r_cell_pr[k+1];
        end

        assign ins_reg = r_gt[k] || (r_occ == OCC_W'(k));
        assign upg_reg = r_gt[k] && !pre_excl[k];

        always_comb begin
            n_cell_id[k] = r_cell_id[k];
            n_cell_pr[k] = r_cell_pr[k];
            unique case (r_op)
                spq_pkg::OP_INSERT: begin
                    if (!full && ins_reg) begin
                        n_cell_id[k] = prev_gt ? prev_id : r_id;
                        n_cell_pr[k] = prev_gt ? prev_pr : r_pr;
                    end
                end
                spq_pkg::OP_POP: begin
                    if (!empty) begin
                        n_cell_id[k] = next_id;
                        n_cell_pr[k] = next_pr;
                    end
                end
                spq_pkg::OP_UPGRADE: begin
                    if (!empty && upg_ok && upg_reg) begin
                        n_cell_id[k] = prev_gt ? prev_id : r_id;
                        n_cell_pr[k] = prev_gt ? prev_pr : r_pr;
                    end
                end
                spq_pkg::OP_CLEAR: begin
                    n_cell_id[k] = r_cell_id[k];
                end
                default: begin
                    n_cell_id[k] = r_cell_id[k];
                end
            endcase
        end
    end

    // cell row update
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            for (int k = 0; k < CAPACITY; k++) begin
                r_cell_id[k] <= n_cell_id[k];
                r_cell_pr[k] <= n_cell_pr[k];
            end
        end
    end

    // count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.apply) begin
            r_occ <= n_occ;
        end
    end

    // result item assembly
    always_comb begin
        n_out.status         = status;
        n_out.popped_id      = ((r_op == spq_pkg::OP_POP) && !empty) ? r_cell_id[0] : '0;
        n_out.front_id       = (n_occ != '0) ? n_cell_id[0] : '0;
        n_out.front_priority = (n_occ != '0) ? n_cell_pr[0] : '0;
        n_out.is_empty       = (n_occ == '0);
        n_out.entry_count    = spq_pkg::COUNT_W'(n_occ);
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_out <= n_out;
        end
    end

    // status to controller
    assign o_stat.scan_done = (r_lvl == LVL_W'(NLEV - 1));
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue with decrease-key.
// Request channel: i_in_valid / o_in_stall carry one operation (insert, pop
// front, upgrade priority, clear all) with an id and a signed priority.
// Result channel: o_out_valid / i_out_stall return exactly one result per
// request: status, popped id, front entry, empty flag and entry count.
// Entries sit in a row of cells kept sorted ascending by priority; every
// cell compares against the request in parallel when it is taken.
// Insert, pop and clear go from the request transfer straight to the apply
// step; upgrade first runs the registered prefix scan that finds the first
// cell holding the id. A new request is taken only after the last is applied.
// A new request is taken while the previous result still waits in the output
// register; if the receiver stalls, the next result is held back in the
// apply step until the output register frees up.
// Reset clears the entry count, so the queue starts empty with no result
// pending; cell contents are not cleared.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spq_pkg::t_out_item o_out_data
);

    spq_pkg::t_dp_cmd  cmd;
    spq_pkg::t_dp_stat stat;

    // sequencing
    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_data.op),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // cell row and result register
    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* test/spq_checker.sv */
module spq_checker #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  spq_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  spq_pkg::t_out_item i_out_data,
    output int                 o_fail_cnt,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_full_cnt,
    output int                 o_empty_cnt,
    output int                 o_notlower_cnt,
    output int                 o_peak
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow copy of the sorted entries
    logic [spq_pkg::ID_W-1:0]          shadow_id   [CAPACITY];
    logic signed [spq_pkg::PRIO_W-1:0] shadow_prio [CAPACITY];
    int                                shadow_count;

    // results owed by the block, oldest first
    spq_pkg::t_out_item awaited_results[$];

    // run one request on the shadow queue and build the result it owes
    function automatic spq_pkg::t_out_item apply_request(spq_pkg::t_in_item req);
        spq_pkg::t_out_item                res;
        logic signed [spq_pkg::PRIO_W-1:0] p;
        int                                pos;
        int                                hit;
        int                                k;
        res        = '0;
        res.status = spq_pkg::ST_OK;
        p          = $signed(req.priority_req);
        case (req.op)
            spq_pkg::OP_INSERT: begin
                if (shadow_count >= CAPACITY) begin
                    res.status = spq_pkg::ST_FULL;
                end else begin
                    // behind every entry of equal or smaller priority
                    pos = 0;
                    while (pos < shadow_count && shadow_prio[pos] <= p) pos++;
                    for (k = shadow_count; k > pos; k--) begin
                        shadow_id[k]   = shadow_id[k-1];
                        shadow_prio[k] = shadow_prio[k-1];
                    end
                    shadow_id[pos]   = req.patient_id;
                    shadow_prio[pos] = p;
                    shadow_count++;
                end
            end
            spq_pkg::OP_POP: begin
                if (shadow_count == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                end else begin
                    res.popped_id = shadow_id[0];
                    for (k = 1; k < shadow_count; k++) begin
                        shadow_id[k-1]   = shadow_id[k];
                        shadow_prio[k-1] = shadow_prio[k];
                    end
                    shadow_count--;
                end
            end
            spq_pkg::OP_UPGRADE: begin
                if (shadow_count == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                end else begin
                    // only the front-most entry with the id counts
                    hit = 0;
                    while (hit < shadow_count && shadow_id[hit] != req.patient_id) hit++;
                    if (hit >= shadow_count || !(shadow_prio[hit] > p)) begin
                        res.status = spq_pkg::ST_NOTLOWER;
                    end else begin
                        // move ahead of greater priorities, stay behind equal ones
                        pos = 0;
                        while (pos < hit && shadow_prio[pos] <= p) pos++;
                        for (k = hit; k > pos; k--) begin
                            shadow_id[k]   = shadow_id[k-1];
                            shadow_prio[k] = shadow_prio[k-1];
                        end
                        shadow_id[pos]   = req.patient_id;
                        shadow_prio[pos] = p;
                    end
                end
            end
            default: begin
                shadow_count = 0;
            end
        endcase
        // front entry and count after the operation
        if (shadow_count > 0) begin
            res.front_id       = shadow_id[0];
            res.front_priority = shadow_prio[0];
            res.is_empty       = 1'b0;
        end else begin
            res.is_empty = 1'b1;
        end
        res.entry_count = shadow_count[spq_pkg::COUNT_W-1:0];
        return res;
    endfunction

    task automatic compare_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_cnt++;
        end
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        spq_pkg::t_out_item want;
        spq_pkg::t_out_item got;
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_results.delete();
        end else begin
            // result transfer: compare with the oldest owed result
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (awaited_results.size() == 0) begin
                    $error("result transfer with nothing owed: %h", got);
                    o_fail_cnt++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("popped_id", want.popped_id, got.popped_id);
                    compare_field("front_id", want.front_id, got.front_id);
                    compare_field("front_priority", $signed(want.front_priority),
                                  $signed(got.front_priority));
                    compare_field("is_empty", want.is_empty, got.is_empty);
                    compare_field("entry_count", want.entry_count, got.entry_count);
                    o_checked++;
                    case (want.status)
                        spq_pkg::ST_FULL:     o_full_cnt++;
                        spq_pkg::ST_EMPTY:    o_empty_cnt++;
                        spq_pkg::ST_NOTLOWER: o_notlower_cnt++;
                        default:              ;
                    endcase
                end
            end
            // request transfer: predict its result
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(apply_request(i_in_data));
                if (shadow_count > o_peak) o_peak = shadow_count;
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

/* test/tb_sorted_priority_queue.sv */
module tb_sorted_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int TAIL_CYCLES  = 20;

    // kinds of random stretches
    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_REKEY,
        PH_MIXED
    } t_phase;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    spq_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_stall;
    spq_pkg::t_out_item out_data;

    // no idling on either side while set
    logic quiet;
    int   stall_left;
    int   cycle_cnt;
    int   op_cnt [4];

    int fail_cnt;
    int pending;
    int checked;
    int full_cnt;
    int empty_cnt;
    int notlower_cnt;
    int peak;

    sorted_priority_queue #(
        .CAPACITY (spq_pkg::CAPACITY_DEF)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    spq_checker #(
        .CAPACITY (spq_pkg::CAPACITY_DEF)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_out_data     (out_data),
        .o_fail_cnt     (fail_cnt),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_cnt     (full_cnt),
        .o_empty_cnt    (empty_cnt),
        .o_notlower_cnt (notlower_cnt),
        .o_peak         (peak)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // one request transfer, starting and ending at a falling edge
    task automatic send_request(input spq_pkg::t_op op,
                                input logic [spq_pkg::ID_W-1:0] id,
                                input logic signed [spq_pkg::PRIO_W-1:0] prio);
        int                gap;
        spq_pkg::t_in_item req;
        gap              = quiet ? 0 : idle_length();
        req.op           = op;
        req.patient_id   = id;
        req.priority_req = prio;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        op_cnt[op]++;
    endtask

    // result side back-pressure
    initial begin
        out_stall  <= 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall  <= 1'b0;
                stall_left = quiet ? 0 : idle_length();
            end
        end
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("run limit of %0d cycles reached, %0d results still owed",
                 CYCLE_LIMIT, pending);
        $display("== FAIL ==");
        $finish;
    end

    // stimulus and verdict
    initial begin
        t_phase                            phase;
        spq_pkg::t_op                      op;
        logic [spq_pkg::ID_W-1:0]          id;
        logic signed [spq_pkg::PRIO_W-1:0] prio;
        int                                issued;
        int                                len;
        int                                n;
        int                                r;

        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        quiet    = 1'b0;
        issued   = 0;
        foreach (op_cnt[i]) op_cnt[i] = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty queue cases
        send_request(spq_pkg::OP_POP,     16'h0000, 16'sh0000);
        send_request(spq_pkg::OP_UPGRADE, 16'h0000, 16'sh8000);
        send_request(spq_pkg::OP_CLEAR,   16'hFFFF, 16'sh7FFF);
        // field extremes, ties and a duplicate id
        send_request(spq_pkg::OP_INSERT,  16'h0000, 16'sh7FFF);
        send_request(spq_pkg::OP_INSERT,  16'hFFFF, 16'sh8000);
        send_request(spq_pkg::OP_INSERT,  16'h0005, 16'sh0000);
        send_request(spq_pkg::OP_INSERT,  16'h0006, 16'sh0000);
        send_request(spq_pkg::OP_INSERT,  16'h0005, 16'sh000A);
        // upgrade of a missing id, equal and greater priority
        send_request(spq_pkg::OP_UPGRADE, 16'h1234, -16'sd5);
        send_request(spq_pkg::OP_UPGRADE, 16'h0006, 16'sh0000);
        send_request(spq_pkg::OP_UPGRADE, 16'h0006, 16'sh0001);
        // upgrades landing behind equal priorities
        send_request(spq_pkg::OP_UPGRADE, 16'h0000, 16'sh0000);
        send_request(spq_pkg::OP_UPGRADE, 16'h0006, 16'sh8000);
        send_request(spq_pkg::OP_UPGRADE, 16'h0005, 16'sh8000);
        send_request(spq_pkg::OP_POP,     16'h0000, 16'sh0000);
        send_request(spq_pkg::OP_POP,     16'h0000, 16'sh0000);
        send_request(spq_pkg::OP_POP,     16'h0000, 16'sh0000);
        // alternating bit patterns
        send_request(spq_pkg::OP_INSERT,  16'h5555, 16'shAAAA);
        send_request(spq_pkg::OP_INSERT,  16'hAAAA, 16'sh5555);
        send_request(spq_pkg::OP_CLEAR,   16'h0000, 16'sh0000);
        send_request(spq_pkg::OP_POP,     16'h0000, 16'sh0000);
        send_request(spq_pkg::OP_INSERT,  16'h0001, -16'sd1);
        send_request(spq_pkg::OP_POP,     16'h0000, 16'sh0000);

        // random stretches, each biased toward one kind of traffic
        while (issued < RANDOM_ITEMS) begin
            phase = t_phase'($urandom_range(0, 3));
            quiet = ($urandom_range(0, 4) == 0);
            len   = (phase == PH_FILL) ? $urandom_range(80, 160) : $urandom_range(40, 120);
            for (n = 0; n < len && issued < RANDOM_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                case (phase)
                    PH_FILL:  op = (r < 80) ? spq_pkg::OP_INSERT :
                                   (r < 90) ? spq_pkg::OP_UPGRADE : spq_pkg::OP_POP;
                    PH_DRAIN: op = (r < 60) ? spq_pkg::OP_POP :
                                   (r < 80) ? spq_pkg::OP_UPGRADE : spq_pkg::OP_INSERT;
                    PH_REKEY: op = (r < 45) ? spq_pkg::OP_INSERT :
                                   (r < 80) ? spq_pkg::OP_UPGRADE : spq_pkg::OP_POP;
                    default:  op = (r < 40) ? spq_pkg::OP_INSERT :
                                   (r < 70) ? spq_pkg::OP_POP :
                                   (r < 97) ? spq_pkg::OP_UPGRADE : spq_pkg::OP_CLEAR;
                endcase
                // small id pool so upgrades find their targets
                r = $urandom_range(0, 9);
                if (r < 7)       id = spq_pkg::ID_W'($urandom_range(0, 11));
                else if (r == 7) id = 16'hFFFF - spq_pkg::ID_W'($urandom_range(0, 3));
                else             id = spq_pkg::ID_W'($urandom());
                // narrow priorities give ties, some extremes and full range
                r = $urandom_range(0, 9);
                if (r < 5)       prio = spq_pkg::PRIO_W'($urandom_range(0, 12)) - 16'sd6;
                else if (r == 5) prio = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                else             prio = spq_pkg::PRIO_W'($urandom());
                send_request(op, id, prio);
                issued++;
            end
        end
        in_valid <= 1'b0;
        quiet    = 1'b1;

        // drain, then a short pause for stray results
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("sent %0d requests: %0d insert, %0d pop, %0d upgrade, %0d clear; %0d checked",
                 op_cnt[0] + op_cnt[1] + op_cnt[2] + op_cnt[3],
                 op_cnt[spq_pkg::OP_INSERT], op_cnt[spq_pkg::OP_POP],
                 op_cnt[spq_pkg::OP_UPGRADE], op_cnt[spq_pkg::OP_CLEAR], checked);
        $display("full %0d, empty %0d, not-lower %0d; peak occupancy %0d of %0d",
                 full_cnt, empty_cnt, notlower_cnt, peak, spq_pkg::CAPACITY_DEF);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
